FILE: src/stss_pkg.sv
// Shared constants and types for the stillness-triggered stimulus sequencer.
`timescale 1ns / 1ps
`default_nettype none

package stss_pkg;

	localparam int NUM_VALVES    = 8;
	localparam int SAMPLE_PERIOD = 5;
	localparam int ADC_BITS      = 10;

	localparam int TIMER_W    = 14;
	localparam int PULSES_W   = 4;
	localparam int COUNT_W    = 16;
	localparam int PRESCALE_W = 3;
	localparam int VALVE_W    = 3;
	localparam int PULSE_W    = 8;
	localparam int DRIVE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_AUTO_MODE     = 3'd0;
	localparam cfg_idx_t REG_VALVE_SELECT  = 3'd1;
	localparam cfg_idx_t REG_DURATION_CODE = 3'd2;
	localparam cfg_idx_t REG_MOVE_THRESH   = 3'd3;
	localparam cfg_idx_t REG_STILL_NEEDED  = 3'd4;
	localparam cfg_idx_t REG_REFRACTORY    = 3'd5;
	localparam cfg_idx_t REG_PULSE_MS      = 3'd6;

	typedef logic [1:0] dur_code_t;

	localparam dur_code_t DUR_100MS   = 2'd0;
	localparam dur_code_t DUR_200MS   = 2'd1;
	localparam dur_code_t DUR_10000MS = 2'd2;
	localparam dur_code_t DUR_INVALID = 2'd3;

	localparam logic [TIMER_W-1:0] HOLD_100MS   = 14'd100;
	localparam logic [TIMER_W-1:0] HOLD_200MS   = 14'd200;
	localparam logic [TIMER_W-1:0] HOLD_10000MS = 14'd10000;

	localparam logic [COUNT_W-1:0]  RST_STILL_NEEDED = 16'd200;
	localparam logic [COUNT_W-1:0]  RST_REFRACTORY   = 16'd10000;
	localparam logic [PULSE_W-1:0]  RST_PULSE_MS     = 8'd5;
	localparam logic [ADC_BITS-1:0] RST_MOVE_THRESH  = 10'd5;
	localparam logic [VALVE_W-1:0]  RST_VALVE_SELECT = 3'd4;

	localparam int OUT_MONITOR_BIT = 8;
	localparam int OUT_DONE_BIT    = 9;
	localparam int OUT_BUSY_BIT    = 10;

endpackage

`default_nettype wire

FILE: src/stillness_triggered_stimulus_sequencer.sv
// Top level of the stillness-triggered stimulus sequencer: sequence control and result register.
//
// Every input item (a one-millisecond tick or a software trigger) gives exactly one result
// item, in the cycle after it is accepted. An item can be accepted on every clock: all the work
// for one item is a handful of compares and counter updates from the sequence state, and the
// result lands in a single output register. s_tready drops only while that register holds a
// result the downstream side has not taken. Configuration writes take effect on the edge at
// which wr_en is high and belong to idle periods between sequences.
`timescale 1ns / 1ps
`default_nettype none

module stillness_triggered_stimulus_sequencer (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// [0] ttl_level, [10:1] velocity, [15:11] zero
	input  wire  [stss_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] action
	input  wire                                 s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// [7:0] valve_drive, [8] monitor_level, [9] stim_done, [10] busy_res, [15:11] zero
	output logic [stss_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire                                 wr_en,
	input  wire  [stss_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire  [stss_pkg::CFG_DATA_W-1:0]     wr_data
);

	import stss_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HOLD = 3'd1,
		PH_GAP  = 3'd2,
		PH_HIGH = 3'd3,
		PH_LOW  = 3'd4
	} phase_t;

	logic                 auto_mode_q;
	logic [VALVE_W-1:0]   valve_select_q;
	dur_code_t            duration_code_q;
	logic [ADC_BITS-1:0]  move_thresh_q;
	logic [COUNT_W-1:0]   still_needed_q;
	logic [COUNT_W-1:0]   refractory_ms_q;
	logic [PULSE_W-1:0]   pulse_ms_q;

	phase_t               phase_q;
	logic [TIMER_W-1:0]   timer_q;
	logic [PULSES_W-1:0]  pulses_left_q;
	logic [COUNT_W-1:0]   still_count_q;
	logic [COUNT_W-1:0]   refr_left_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic                 ttl_prev_q;
	logic [VALVE_W-1:0]   latched_valve_q;
	logic                 auto_origin_q;

	phase_t               phase_d;
	logic [TIMER_W-1:0]   timer_d;
	logic [PULSES_W-1:0]  pulses_left_d;
	logic [COUNT_W-1:0]   still_count_d;
	logic [COUNT_W-1:0]   refr_left_d;
	logic [PRESCALE_W-1:0] prescale_d;
	logic                 ttl_prev_d;
	logic [VALVE_W-1:0]   latched_valve_d;
	logic                 auto_origin_d;
	logic                 done_d;
	logic [OUT_DATA_W-1:0] result_d;

	logic                 accept;
	logic                 action;
	logic                 ttl_level;
	logic [ADC_BITS-1:0]  velocity;
	logic [TIMER_W-1:0]   pulse_time;
	logic [TIMER_W-1:0]   hold_time;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !m_tvalid || m_tready;
	assign action    = s_tuser;
	assign ttl_level = s_tdata[0];
	assign velocity  = s_tdata[ADC_BITS:1];

	assign pulse_time = (pulse_ms_q == '0) ? TIMER_W'(1) : TIMER_W'(pulse_ms_q);

	always_comb begin
		unique case (duration_code_q)
			DUR_100MS:   hold_time = HOLD_100MS;
			DUR_200MS:   hold_time = HOLD_200MS;
			default:     hold_time = HOLD_10000MS;
		endcase
	end

	always_comb begin
		logic [TIMER_W-1:0]    t_dec;
		logic [PULSES_W-1:0]   p_dec;
		logic [PRESCALE_W-1:0] ps_inc;
		logic [COUNT_W-1:0]    sc;
		logic                  start;
		logic                  from_auto;
		logic [DRIVE_W-1:0]    drive;

		phase_d         = phase_q;
		timer_d         = timer_q;
		pulses_left_d   = pulses_left_q;
		still_count_d   = still_count_q;
		refr_left_d     = refr_left_q;
		prescale_d      = prescale_q;
		ttl_prev_d      = ttl_prev_q;
		latched_valve_d = latched_valve_q;
		auto_origin_d   = auto_origin_q;
		done_d          = 1'b0;
		start           = 1'b0;
		from_auto       = 1'b0;
		t_dec           = (timer_q != '0) ? timer_q - TIMER_W'(1) : timer_q;
		p_dec           = (pulses_left_q != '0) ? pulses_left_q - PULSES_W'(1) : pulses_left_q;
		ps_inc          = prescale_q + PRESCALE_W'(1);
		sc              = still_count_q;

		if (action) begin
			start = (phase_q == PH_IDLE);
		end else begin
			if (refr_left_q != '0) begin
				refr_left_d = refr_left_q - COUNT_W'(1);
			end
			if (phase_q != PH_IDLE) begin
				timer_d = t_dec;
				if (t_dec == '0) begin
					unique case (phase_q)
						PH_HOLD: begin
							phase_d = PH_GAP;
							timer_d = pulse_time;
						end
						PH_GAP: begin
							phase_d       = PH_HIGH;
							timer_d       = pulse_time;
							pulses_left_d = PULSES_W'(latched_valve_q) + PULSES_W'(1);
						end
						PH_HIGH: begin
							phase_d = PH_LOW;
							timer_d = pulse_time;
						end
						default: begin
							pulses_left_d = p_dec;
							if (p_dec != '0) begin
								phase_d = PH_HIGH;
								timer_d = pulse_time;
							end else begin
								phase_d       = PH_IDLE;
								auto_origin_d = 1'b0;
								done_d        = 1'b1;
								if (!auto_origin_q) begin
									refr_left_d = refractory_ms_q;
								end
							end
						end
					endcase
				end
			end else if (auto_mode_q) begin
				prescale_d = ps_inc;
				if (32'(ps_inc) >= SAMPLE_PERIOD) begin
					prescale_d = '0;
					if (refr_left_d == '0) begin
						if (velocity <= move_thresh_q) begin
							if (sc != '1) begin
								sc = sc + COUNT_W'(1);
							end
						end else begin
							sc = '0;
						end
						still_count_d = sc;
						if (sc >= still_needed_q) begin
							still_count_d = '0;
							start         = 1'b1;
							from_auto     = 1'b1;
						end
					end
				end
			end else if (ttl_level != ttl_prev_q) begin
				ttl_prev_d = ttl_level;
				start      = !ttl_prev_q;
			end
		end

		if (start) begin
			phase_d         = PH_HOLD;
			timer_d         = hold_time;
			latched_valve_d = valve_select_q;
			pulses_left_d   = '0;
			auto_origin_d   = from_auto;
			if (from_auto) begin
				refr_left_d = refractory_ms_q;
			end
		end

		drive = '0;
		if (phase_d == PH_HOLD && 32'(latched_valve_d) < NUM_VALVES) begin
			drive = DRIVE_W'(1) << latched_valve_d;
		end
		result_d                  = '0;
		result_d[DRIVE_W-1:0]     = drive;
		result_d[OUT_MONITOR_BIT] = (phase_d == PH_HOLD) || (phase_d == PH_HIGH);
		result_d[OUT_DONE_BIT]    = done_d;
		result_d[OUT_BUSY_BIT]    = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q     <= 1'b0;
			valve_select_q  <= RST_VALVE_SELECT;
			duration_code_q <= DUR_200MS;
			move_thresh_q   <= RST_MOVE_THRESH;
			still_needed_q  <= RST_STILL_NEEDED;
			refractory_ms_q <= RST_REFRACTORY;
			pulse_ms_q      <= RST_PULSE_MS;
			phase_q         <= PH_IDLE;
			timer_q         <= '0;
			pulses_left_q   <= '0;
			still_count_q   <= '0;
			refr_left_q     <= RST_REFRACTORY;
			prescale_q      <= '0;
			ttl_prev_q      <= 1'b0;
			latched_valve_q <= '0;
			auto_origin_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_AUTO_MODE: begin
					auto_mode_q <= wr_data[0];
					if (!wr_data[0]) begin
						still_count_q <= '0;
					end
				end
				REG_VALVE_SELECT:  valve_select_q <= wr_data[VALVE_W-1:0];
				REG_DURATION_CODE: begin
					if (wr_data[1:0] != DUR_INVALID) begin
						duration_code_q <= wr_data[1:0];
					end
				end
				REG_MOVE_THRESH:   move_thresh_q   <= wr_data[ADC_BITS-1:0];
				REG_STILL_NEEDED:  still_needed_q  <= wr_data[COUNT_W-1:0];
				REG_REFRACTORY:    refractory_ms_q <= wr_data[COUNT_W-1:0];
				REG_PULSE_MS:      pulse_ms_q      <= wr_data[PULSE_W-1:0];
				default: begin
				end
			endcase
		end else if (accept) begin
			phase_q         <= phase_d;
			timer_q         <= timer_d;
			pulses_left_q   <= pulses_left_d;
			still_count_q   <= still_count_d;
			refr_left_q     <= refr_left_d;
			prescale_q      <= prescale_d;
			ttl_prev_q      <= ttl_prev_d;
			latched_valve_q <= latched_valve_d;
			auto_origin_q   <= auto_origin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata <= result_d;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_DONE_BIT] |-> !m_tdata[OUT_BUSY_BIT])
		else $error("done result still marked busy");

	a_drive_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[DRIVE_W-1:0] != '0) |->
			$onehot(m_tdata[DRIVE_W-1:0]) && m_tdata[OUT_MONITOR_BIT] && m_tdata[OUT_BUSY_BIT])
		else $error("valve driven outside stimulus hold");

	a_end_flags_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !wr_en && (phase_q != PH_IDLE) |=>
			(phase_q != PH_IDLE) || m_tdata[OUT_DONE_BIT])
		else $error("sequence ended without done");

	a_pulses_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HIGH) || (phase_q == PH_LOW) |-> pulses_left_q != '0)
		else $error("code pulse phase with no pulses left");

endmodule

`default_nettype wire

FILE: sim/stss_output_checker.sv
// Output checker for the stimulus sequencer: tracks config writes, predicts and compares items.
`timescale 1ns / 1ps

package stss_tb_pkg;

	typedef enum logic {
		ACT_TICK    = 1'b0,
		ACT_TRIGGER = 1'b1
	} action_t;

endpackage

module stss_output_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	input  wire                               s_tready,
	// [0] ttl_level, [10:1] velocity, [15:11] zero
	input  wire  [stss_pkg::IN_DATA_W-1:0]    s_tdata,
	// [0] action
	input  wire                               s_tuser,
	input  wire                               m_tvalid,
	input  wire                               m_tready,
	// [7:0] valve_drive, [8] monitor_level, [9] stim_done, [10] busy_res, [15:11] zero
	input  wire  [stss_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  wire                               wr_en,
	input  wire  [stss_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire  [stss_pkg::CFG_DATA_W-1:0]   wr_data,
	output int                                errors,
	output int                                pending
);

	import stss_pkg::*;
	import stss_tb_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_HOLD,
		SEQ_GAP,
		SEQ_HIGH,
		SEQ_LOW
	} seq_phase_t;

	typedef struct {
		logic [DRIVE_W-1:0] valve_drive;
		logic               monitor_level;
		logic               stim_done;
		logic               busy_res;
	} stim_out_t;

	logic                auto_mode;
	logic [VALVE_W-1:0]  valve_sel;
	dur_code_t           dur_code;
	logic [ADC_BITS-1:0] move_thresh;
	logic [COUNT_W-1:0]  still_needed;
	logic [COUNT_W-1:0]  refr_ms;
	logic [PULSE_W-1:0]  pulse_ms;

	seq_phase_t          phase;
	int unsigned         phase_timer;
	logic [PULSES_W-1:0] pulses_left;
	logic [COUNT_W-1:0]  still_count;
	logic [COUNT_W-1:0]  refr_left;
	int unsigned         prescale;
	logic                ttl_prev;
	logic [VALVE_W-1:0]  held_valve;
	logic                auto_started;

	stim_out_t expected_outputs[$];
	int        fail_count = 0;

	function automatic int unsigned pulse_ticks();
		return (pulse_ms == '0) ? 1 : int'(pulse_ms);
	endfunction

	function automatic void open_hold(logic from_auto);
		phase = SEQ_HOLD;
		case (dur_code)
			DUR_100MS: phase_timer = 32'(HOLD_100MS);
			DUR_200MS: phase_timer = 32'(HOLD_200MS);
			default: phase_timer = 32'(HOLD_10000MS);
		endcase
		held_valve = valve_sel;
		pulses_left = '0;
		auto_started = from_auto;
		if (from_auto) refr_left = refr_ms;
	endfunction

	function automatic stim_out_t next_outputs(action_t action, logic ttl,
			logic [ADC_BITS-1:0] vel);
		stim_out_t res;
		logic      done;
		done = 1'b0;
		if (action == ACT_TRIGGER) begin
			if (phase == SEQ_IDLE) open_hold(1'b0);
		end else begin
			if (refr_left != '0) refr_left--;
			if (phase != SEQ_IDLE) begin
				if (phase_timer != 0) phase_timer--;
				if (phase_timer == 0) begin
					case (phase)
						SEQ_HOLD: begin
							phase = SEQ_GAP;
							phase_timer = pulse_ticks();
						end
						SEQ_GAP: begin
							phase = SEQ_HIGH;
							phase_timer = pulse_ticks();
							pulses_left = PULSES_W'(held_valve) + PULSES_W'(1);
						end
						SEQ_HIGH: begin
							phase = SEQ_LOW;
							phase_timer = pulse_ticks();
						end
						default: begin
							if (pulses_left != '0) pulses_left--;
							if (pulses_left != '0) begin
								phase = SEQ_HIGH;
								phase_timer = pulse_ticks();
							end else begin
								phase = SEQ_IDLE;
								if (!auto_started) refr_left = refr_ms;
								auto_started = 1'b0;
								done = 1'b1;
							end
						end
					endcase
				end
			end else if (auto_mode) begin
				prescale++;
				if (prescale >= SAMPLE_PERIOD) begin
					prescale = 0;
					if (refr_left == '0) begin
						if (vel <= move_thresh) begin
							if (still_count != '1) still_count++;
						end else begin
							still_count = '0;
						end
						if (still_count >= still_needed) begin
							still_count = '0;
							open_hold(1'b1);
						end
					end
				end
			end else if (ttl != ttl_prev) begin
				if (!ttl_prev) open_hold(1'b0);
				ttl_prev = ttl;
			end
		end
		res.valve_drive = (phase == SEQ_HOLD && held_valve < NUM_VALVES) ?
			DRIVE_W'(1 << held_valve) : '0;
		res.monitor_level = (phase == SEQ_HOLD || phase == SEQ_HIGH);
		res.stim_done = done;
		res.busy_res = (phase != SEQ_IDLE);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stim_out_t want;
		if (!arst_n) begin
			auto_mode = 1'b0;
			valve_sel = RST_VALVE_SELECT;
			dur_code = DUR_200MS;
			move_thresh = RST_MOVE_THRESH;
			still_needed = RST_STILL_NEEDED;
			refr_ms = RST_REFRACTORY;
			pulse_ms = RST_PULSE_MS;
			phase = SEQ_IDLE;
			phase_timer = 0;
			pulses_left = '0;
			still_count = '0;
			refr_left = RST_REFRACTORY;
			prescale = 0;
			ttl_prev = 1'b0;
			held_valve = '0;
			auto_started = 1'b0;
			expected_outputs.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_outputs.size() == 0) begin
					$error("output item with nothing expected: %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_outputs.pop_front();
					if (m_tdata[DRIVE_W-1:0] !== want.valve_drive) begin
						$error("valve_drive: expected %h, got %h", want.valve_drive,
							m_tdata[DRIVE_W-1:0]);
						fail_count++;
					end
					if (m_tdata[OUT_MONITOR_BIT] !== want.monitor_level) begin
						$error("monitor_level: expected %b, got %b", want.monitor_level,
							m_tdata[OUT_MONITOR_BIT]);
						fail_count++;
					end
					if (m_tdata[OUT_DONE_BIT] !== want.stim_done) begin
						$error("stim_done: expected %b, got %b", want.stim_done,
							m_tdata[OUT_DONE_BIT]);
						fail_count++;
					end
					if (m_tdata[OUT_BUSY_BIT] !== want.busy_res) begin
						$error("busy_res: expected %b, got %b", want.busy_res,
							m_tdata[OUT_BUSY_BIT]);
						fail_count++;
					end
					if (m_tdata[OUT_DATA_W-1:OUT_BUSY_BIT+1] !== '0) begin
						$error("padding: expected 0, got %h",
							m_tdata[OUT_DATA_W-1:OUT_BUSY_BIT+1]);
						fail_count++;
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_AUTO_MODE: begin
						auto_mode = wr_data[0];
						if (!wr_data[0]) still_count = '0;
					end
					REG_VALVE_SELECT: valve_sel = wr_data[VALVE_W-1:0];
					REG_DURATION_CODE: begin
						if (wr_data[1:0] != DUR_INVALID) dur_code = wr_data[1:0];
					end
					REG_MOVE_THRESH: move_thresh = wr_data[ADC_BITS-1:0];
					REG_STILL_NEEDED: still_needed = wr_data[COUNT_W-1:0];
					REG_REFRACTORY: refr_ms = wr_data[COUNT_W-1:0];
					REG_PULSE_MS: pulse_ms = wr_data[PULSE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_outputs.push_back(next_outputs(action_t'(s_tuser), s_tdata[0],
					s_tdata[ADC_BITS:1]));
		end
		errors <= fail_count;
		pending <= expected_outputs.size();
	end

endmodule

FILE: sim/stillness_triggered_stimulus_sequencer_tb.sv
// Testbench top for the stimulus sequencer: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module stillness_triggered_stimulus_sequencer_tb;

	import stss_pkg::*;
	import stss_tb_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  wr_en = 1'b0;
	cfg_idx_t              wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	int                  errors;
	int                  pending;
	int                  idle_cycles = 0;
	bit                  hold_off_pending = 1'b0;
	int                  send_burst_left = 0;
	logic                ttl_now = 1'b0;
	logic [ADC_BITS-1:0] thresh_now = RST_MOVE_THRESH;

	stillness_triggered_stimulus_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	stss_output_checker i_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int sender_gap();
		int r;
		if (send_burst_left > 0) begin
			send_burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			send_burst_left = $urandom_range(30, 150);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic offer_item(action_t action, logic ttl, logic [ADC_BITS-1:0] vel);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= action;
		s_tdata <= IN_DATA_W'({vel, ttl});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic offer_random(int count);
		int                  r;
		logic [ADC_BITS-1:0] vel;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 3) ttl_now = ~ttl_now;
			vel = ($urandom_range(0, 3) != 0) ? ADC_BITS'($urandom_range(0, thresh_now)) :
				ADC_BITS'($urandom_range(0, 1023));
			if (r >= 97)
				offer_item(ACT_TRIGGER, 1'($urandom_range(0, 1)), vel);
			else if (r >= 92)
				offer_item(ACT_TICK, 1'($urandom_range(0, 1)),
					ADC_BITS'($urandom_range(0, 1023)));
			else
				offer_item(ACT_TICK, ttl_now, vel);
		end
	endtask

	task automatic quiesce();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		if (idx == REG_MOVE_THRESH) thresh_now = val[ADC_BITS-1:0];
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic shuffle_config();
		write_reg(REG_VALVE_SELECT, CFG_DATA_W'($urandom_range(0, 7)));
		write_reg(REG_DURATION_CODE,
			CFG_DATA_W'(($urandom_range(0, 1) != 0) ? DUR_200MS : DUR_100MS));
		if ($urandom_range(0, 4) == 0) write_reg(REG_DURATION_CODE, CFG_DATA_W'(DUR_INVALID));
		write_reg(REG_MOVE_THRESH, CFG_DATA_W'($urandom_range(0, 1023)));
		write_reg(REG_STILL_NEEDED, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
			$urandom_range(0, 65535) : $urandom_range(0, 6)));
		write_reg(REG_REFRACTORY, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
			$urandom_range(0, 65535) : $urandom_range(0, 300)));
		write_reg(REG_PULSE_MS, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
			$urandom_range(0, 255) : $urandom_range(0, 12)));
		write_reg(REG_AUTO_MODE, CFG_DATA_W'($urandom_range(0, 1)));
	endtask

	initial begin
		int stall_left;
		int steady_left;
		int r;
		stall_left = 0;
		steady_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (steady_left > 0) begin
					steady_left--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3)
						steady_left = $urandom_range(50, 200);
					else if (r < 60)
						stall_left = 0;
					else if (r < 92)
						stall_left = $urandom_range(1, 3);
					else if (r < 98)
						stall_left = $urandom_range(4, 12);
					else
						stall_left = $urandom_range(20, 60);
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset configuration, TTL edge mode
		offer_item(ACT_TICK, 1'b0, 10'd0);
		offer_item(ACT_TICK, 1'b0, 10'd1023);
		offer_item(ACT_TICK, 1'b1, 10'd0);
		offer_item(ACT_TICK, 1'b0, 10'd1023);
		offer_item(ACT_TRIGGER, 1'b1, 10'd1023);
		offer_item(ACT_TICK, 1'b1, 10'd512);
		ttl_now = 1'b1;
		offer_random(90);
		quiesce();

		// shortest hold, zero pulse time, rejected duration code
		write_reg(REG_DURATION_CODE, CFG_DATA_W'(DUR_100MS));
		write_reg(REG_DURATION_CODE, CFG_DATA_W'(DUR_INVALID));
		write_reg(REG_VALVE_SELECT, CFG_DATA_W'(0));
		write_reg(REG_PULSE_MS, CFG_DATA_W'(0));
		write_reg(REG_REFRACTORY, CFG_DATA_W'(0));
		write_reg(REG_AUTO_MODE, CFG_DATA_W'(0));
		offer_item(ACT_TRIGGER, 1'b0, 10'd0);
		offer_item(ACT_TRIGGER, 1'b1, 10'd0);
		offer_random(100);
		quiesce();

		// stillness mode, every sample fires
		write_reg(REG_STILL_NEEDED, CFG_DATA_W'(0));
		write_reg(REG_MOVE_THRESH, CFG_DATA_W'(1023));
		write_reg(REG_VALVE_SELECT, CFG_DATA_W'(7));
		write_reg(REG_PULSE_MS, CFG_DATA_W'(1));
		write_reg(REG_AUTO_MODE, CFG_DATA_W'(1));
		offer_random(120);
		quiesce();

		// threshold boundary, longest refractory window
		write_reg(REG_STILL_NEEDED, CFG_DATA_W'(3));
		write_reg(REG_MOVE_THRESH, CFG_DATA_W'(100));
		write_reg(REG_REFRACTORY, CFG_DATA_W'(65535));
		repeat (5) offer_item(ACT_TICK, 1'b0, 10'd100);
		repeat (5) offer_item(ACT_TICK, 1'b0, 10'd101);
		offer_random(60);
		quiesce();

		write_reg(REG_DURATION_CODE, CFG_DATA_W'(DUR_100MS));
		write_reg(REG_STILL_NEEDED, CFG_DATA_W'(65535));
		write_reg(REG_REFRACTORY, CFG_DATA_W'(0));
		write_reg(REG_MOVE_THRESH, CFG_DATA_W'(1023));
		write_reg(REG_AUTO_MODE, CFG_DATA_W'(1));
		offer_random(60);
		quiesce();

		for (int round = 0; round < 8; round++) begin
			shuffle_config();
			if (round == 0) hold_off_pending = 1'b1;
			offer_random($urandom_range(10, 30));
			if ($urandom_range(0, 1) != 0) begin
				quiesce();
				write_reg(REG_AUTO_MODE, CFG_DATA_W'($urandom_range(0, 1)));
				write_reg(REG_AUTO_MODE, CFG_DATA_W'(1));
				offer_random(10);
			end
			quiesce();
		end

		// longest hold, longest pulse time
		write_reg(REG_AUTO_MODE, CFG_DATA_W'(0));
		write_reg(REG_PULSE_MS, CFG_DATA_W'(255));
		write_reg(REG_VALVE_SELECT, CFG_DATA_W'(0));
		write_reg(REG_REFRACTORY, CFG_DATA_W'(20));
		write_reg(REG_DURATION_CODE, CFG_DATA_W'(DUR_10000MS));
		offer_item(ACT_TRIGGER, 1'b0, 10'd0);
		offer_random(40);
		quiesce();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/stss_pkg.sv
src/stillness_triggered_stimulus_sequencer.sv
sim/stss_output_checker.sv
sim/stillness_triggered_stimulus_sequencer_tb.sv
